/* sv/fra_pkg.sv */
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and constants for the fraction reduce and add block.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int SUM_W         = PROD_W + 1;
  localparam int CNT_W         = $clog2(SUM_W + 1);
  localparam int EXT_W         = (SUM_W > 33) ? SUM_W : 33;

  localparam logic CMD_REDUCE = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  typedef struct packed {
    logic                            command;
    logic signed [OPERAND_WIDTH-1:0] num_a;
    logic signed [OPERAND_WIDTH-1:0] den_a;
    logic signed [OPERAND_WIDTH-1:0] num_b;
    logic signed [OPERAND_WIDTH-1:0] den_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] num_out;
    logic        [29:0] den_out;
    logic               status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_ADD, S_CHK, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_AD, MUL_BC, MUL_DD
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     do_add;
    logic     gcd_load;
    logic     gcd_step;
    logic     div_load_num;
    logic     div_load_den;
    logic     div_step;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic err;
    logic zero;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

/* sv/fra_ctrl.sv */
// ----------------------------------------------------------------------------
// fra_ctrl
// Sequencer: multiply, combine, gcd and both divisions unless err/zero, emit.
// ----------------------------------------------------------------------------
module fra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fra_pkg::dp_status_t sts,
  output fra_pkg::ctrl_cmd_t  cmd
);

  fra_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fra_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = fra_pkg::MUL_AD;
    in_stall  = (state_r != fra_pkg::S_IDLE);
    unique case (state_r)
      fra_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = fra_pkg::S_MUL1;
        end
      end
      fra_pkg::S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = fra_pkg::MUL_AD;
        state_nxt   = fra_pkg::S_MUL2;
      end
      fra_pkg::S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = fra_pkg::MUL_BC;
        state_nxt   = fra_pkg::S_MUL3;
      end
      fra_pkg::S_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = fra_pkg::MUL_DD;
        state_nxt   = fra_pkg::S_ADD;
      end
      fra_pkg::S_ADD: begin
        cmd.do_add = 1'b1;
        state_nxt  = fra_pkg::S_CHK;
      end
      fra_pkg::S_CHK: begin
        if (sts.err || sts.zero) begin
          state_nxt = fra_pkg::S_DONE;
        end else begin
          cmd.gcd_load = 1'b1;
          state_nxt    = fra_pkg::S_GCD;
        end
      end
      fra_pkg::S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_load_num = 1'b1;
          state_nxt        = fra_pkg::S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      fra_pkg::S_DIVN: begin
        if (sts.div_done) begin
          cmd.div_load_den = 1'b1;
          state_nxt        = fra_pkg::S_DIVD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      fra_pkg::S_DIVD: begin
        if (sts.div_done) begin
          state_nxt = fra_pkg::S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      fra_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = fra_pkg::S_IDLE;
        end
      end
      default: state_nxt = fra_pkg::S_IDLE;
    endcase
  end

endmodule

/* sv/fra_dpath.sv */
// ----------------------------------------------------------------------------
// fra_dpath
// Operand magnitudes, shared multiplier, binary gcd, restoring divider and
// the output register.
// ----------------------------------------------------------------------------
module fra_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  fra_pkg::in_word_t   in_word,
  input  fra_pkg::ctrl_cmd_t  cmd,
  output fra_pkg::dp_status_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output fra_pkg::out_word_t  out_word
);

  localparam int W  = fra_pkg::OPERAND_WIDTH;
  localparam int PW = fra_pkg::PROD_W;
  localparam int SW = fra_pkg::SUM_W;
  localparam int CW = fra_pkg::CNT_W;
  localparam int EW = fra_pkg::EXT_W;
  localparam logic [EW-1:0] NUM_POS_MAX = EW'(64'h7FFF_FFFF);
  localparam logic [EW-1:0] NUM_NEG_MAX = EW'(64'h8000_0000);
  localparam logic [EW-1:0] DEN_MAX     = EW'(64'h3FFF_FFFF);

  logic          cmd_r;
  logic [W-1:0]  na_r, da_r, nb_r, db_r;
  logic          s1_r, s2_r;
  logic [PW-1:0] m1_r, m2_r, dd_r;
  logic [SW-1:0] mag_r, den_r;
  logic          neg_r, err_r, zero_r;
  logic [SW-1:0] gx_r, gy_r, g_r;
  logic [CW-1:0] gk_r;
  logic [SW-1:0] q_r, r_r, nq_r;
  logic [CW-1:0] dc_r;
  logic          ov_r, ov_nxt;
  fra_pkg::out_word_t ow_r;

  function automatic logic [W:0] split(input logic [W-1:0] v);
    logic [W-1:0] m;
    m = v[W-1] ? (~v + W'(1)) : v;
    return {v[W-1], m};
  endfunction

  logic [W:0]    sp_na, sp_da, sp_nb, sp_db;
  logic [W-1:0]  ma, mb;
  logic [PW-1:0] prod;
  logic [SW-1:0] m1e, m2e, mag_nxt, den_nxt;
  logic          neg_nxt, err_nxt;
  logic [SW:0]   dtry, dsub;
  logic [EW-1:0] nq_e, dq_e, nsat;

  assign sp_na = split(in_word.num_a);
  assign sp_da = split(in_word.den_a);
  assign sp_nb = split(in_word.num_b);
  assign sp_db = split(in_word.den_b);

  always_comb begin
    unique case (cmd.mul_sel)
      fra_pkg::MUL_AD: begin ma = na_r; mb = db_r; end
      fra_pkg::MUL_BC: begin ma = nb_r; mb = da_r; end
      fra_pkg::MUL_DD: begin ma = da_r; mb = db_r; end
      default:         begin ma = da_r; mb = db_r; end
    endcase
    prod = PW'(ma) * PW'(mb);
  end

  always_comb begin
    m1e = SW'(m1_r);
    m2e = SW'(m2_r);
    if (cmd_r == fra_pkg::CMD_REDUCE) begin
      mag_nxt = SW'(na_r);
      den_nxt = SW'(da_r);
      neg_nxt = s1_r;
      err_nxt = (da_r == '0);
    end else begin
      den_nxt = SW'(dd_r);
      err_nxt = (da_r == '0) || (db_r == '0);
      if (s1_r == s2_r) begin
        mag_nxt = m1e + m2e;
        neg_nxt = s1_r;
      end else if (m1e >= m2e) begin
        mag_nxt = m1e - m2e;
        neg_nxt = s1_r;
      end else begin
        mag_nxt = m2e - m1e;
        neg_nxt = s2_r;
      end
    end
  end

  assign dtry = {r_r, q_r[SW-1]};
  assign dsub = dtry - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_word.command;
      na_r  <= sp_na[W-1:0];
      da_r  <= sp_da[W-1:0];
      nb_r  <= sp_nb[W-1:0];
      db_r  <= sp_db[W-1:0];
      s1_r  <= sp_na[W] ^ sp_da[W];
      s2_r  <= sp_nb[W] ^ sp_db[W];
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        fra_pkg::MUL_AD: m1_r <= prod;
        fra_pkg::MUL_BC: m2_r <= prod;
        fra_pkg::MUL_DD: dd_r <= prod;
        default:         dd_r <= prod;
      endcase
    end
    if (cmd.do_add) begin
      mag_r  <= mag_nxt;
      den_r  <= den_nxt;
      neg_r  <= neg_nxt;
      err_r  <= err_nxt;
      zero_r <= (mag_nxt == '0);
    end
    // binary gcd, one step a cycle
    if (cmd.gcd_load) begin
      gx_r <= mag_r;
      gy_r <= den_r;
      gk_r <= '0;
    end else if (cmd.gcd_step) begin
      priority if (!gx_r[0] && !gy_r[0]) begin
        gx_r <= gx_r >> 1;
        gy_r <= gy_r >> 1;
        gk_r <= gk_r + CW'(1);
      end else if (!gx_r[0]) begin
        gx_r <= gx_r >> 1;
      end else if (!gy_r[0]) begin
        gy_r <= gy_r >> 1;
      end else if (gx_r >= gy_r) begin
        gx_r <= gx_r - gy_r;
      end else begin
        gy_r <= gy_r - gx_r;
      end
    end
    // restoring division, one quotient bit a cycle
    if (cmd.div_load_num) begin
      g_r  <= gy_r << gk_r;
      q_r  <= mag_r;
      r_r  <= '0;
      dc_r <= '0;
    end else if (cmd.div_load_den) begin
      nq_r <= q_r;
      q_r  <= den_r;
      r_r  <= '0;
      dc_r <= '0;
    end else if (cmd.div_step) begin
      dc_r <= dc_r + CW'(1);
      if (!dsub[SW]) begin
        r_r <= dsub[SW-1:0];
        q_r <= {q_r[SW-2:0], 1'b1};
      end else begin
        r_r <= dtry[SW-1:0];
        q_r <= {q_r[SW-2:0], 1'b0};
      end
    end
  end

  assign nq_e = EW'(nq_r);
  assign dq_e = EW'(q_r);

  always_comb begin
    if (neg_r) begin
      nsat = (nq_e > NUM_NEG_MAX) ? NUM_NEG_MAX : nq_e;
      nsat = ~nsat + EW'(1);
    end else begin
      nsat = (nq_e > NUM_POS_MAX) ? NUM_POS_MAX : nq_e;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.load_out) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      priority if (err_r) begin
        ow_r.num_out <= '0;
        ow_r.den_out <= '0;
        ow_r.status  <= 1'b1;
      end else if (zero_r) begin
        ow_r.num_out <= '0;
        ow_r.den_out <= 30'd1;
        ow_r.status  <= 1'b0;
      end else begin
        ow_r.num_out <= nsat[31:0];
        ow_r.den_out <= (dq_e > DEN_MAX) ? DEN_MAX[29:0] : dq_e[29:0];
        ow_r.status  <= 1'b0;
      end
    end
  end

  assign sts.err      = err_r;
  assign sts.zero     = zero_r;
  assign sts.gcd_done = (gx_r == '0);
  assign sts.div_done = (dc_r == CW'(SW));
  assign sts.out_free = !ov_r || !out_stall;
  assign out_valid    = ov_r;
  assign out_word     = ow_r;

endmodule

/* sv/fraction_reduce_and_add_top.sv */
// ----------------------------------------------------------------------------
// fraction_reduce_and_add_top
// Reduces one signed fraction, or adds two, giving the result in lowest terms.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A reduce or add is accepted, then the
// multiplier forms the two cross products and the denominator product, the
// terms are combined and checked, the binary gcd loop runs, the bit-serial
// divider divides numerator and then denominator by the gcd, and the result
// is emitted. Zero numerators and zero denominators skip straight to the
// output. The emit cycle waits while an earlier result is still stalled.
// The result register lets the next word be taken while a result waits.
module fraction_reduce_and_add_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fra_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output fra_pkg::out_word_t out_word
);

  fra_pkg::ctrl_cmd_t  cmd;
  fra_pkg::dp_status_t sts;

  fra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fra_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* sv/fra_checker.sv */
// ----------------------------------------------------------------------------
// fra_checker
// Port level checks for the fraction reduce and add block.
// ----------------------------------------------------------------------------
module fra_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input fra_pkg::out_word_t out_word
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status |-> out_word.num_out == 0 && out_word.den_out == 0)
    else $error("error word carries nonzero fields");

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.status |-> out_word.den_out != 0)
    else $error("valid result with zero denominator");

  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.status && out_word.num_out == 0 |-> out_word.den_out == 1)
    else $error("zero numerator not given as 0/1");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a word");

endmodule

bind fraction_reduce_and_add_top fra_checker u_fra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* dv/tb_fraction_reduce_and_add_top.sv */
// ----------------------------------------------------------------------------
// tb_fraction_reduce_and_add_top
// Drives reduce and add words with random bursts and output stalls, predicts
// each reduced fraction and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class fraction_scoreboard;
  fra_pkg::out_word_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function longint unsigned split_mag(logic [fra_pkg::OPERAND_WIDTH-1:0] raw,
                                             output bit neg);
    longint unsigned v;
    v = 64'(raw);
    neg = raw[fra_pkg::OPERAND_WIDTH-1];
    if (neg) v = (longint'(1) << fra_pkg::OPERAND_WIDTH) - v;
    return v;
  endfunction

  static function fra_pkg::out_word_t lowest_terms(longint unsigned nmag,
                                                   longint unsigned dmag,
                                                   bit neg, bit err);
    fra_pkg::out_word_t r;
    longint unsigned x, y, t;
    r = '0;
    if (err) begin
      r.status = 1'b1;
      return r;
    end
    if (nmag == 0) begin
      r.den_out = 30'd1;
      return r;
    end
    x = nmag;
    y = dmag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nmag = nmag / x;
    dmag = dmag / x;
    if (dmag > 64'h3FFFFFFF) dmag = 64'h3FFFFFFF;
    if (neg) begin
      if (nmag > 64'h80000000) nmag = 64'h80000000;
      r.num_out = 32'(-nmag);
    end else begin
      if (nmag > 64'h7FFFFFFF) nmag = 64'h7FFFFFFF;
      r.num_out = 32'(nmag);
    end
    r.den_out = 30'(dmag);
    return r;
  endfunction

  function void note_word(fra_pkg::in_word_t w);
    bit sna, sda, snb, sdb, s1, s2, neg;
    longint unsigned na, da, nb, db, m1, m2, mag;
    na = split_mag(w.num_a, sna);
    da = split_mag(w.den_a, sda);
    nb = split_mag(w.num_b, snb);
    db = split_mag(w.den_b, sdb);
    if (w.command == fra_pkg::CMD_REDUCE) begin
      pending.push_back(lowest_terms(na, da, sna != sda, da == 0));
    end else if (da == 0 || db == 0) begin
      pending.push_back(lowest_terms(0, 0, 0, 1));
    end else begin
      m1 = na * db;
      m2 = nb * da;
      s1 = sna != sda;
      s2 = snb != sdb;
      if (s1 == s2) begin
        mag = m1 + m2;
        neg = s1;
      end else if (m1 >= m2) begin
        mag = m1 - m2;
        neg = s1;
      end else begin
        mag = m2 - m1;
        neg = s2;
      end
      pending.push_back(lowest_terms(mag, da * db, neg, 0));
    end
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_word(fra_pkg::out_word_t got);
    fra_pkg::out_word_t want;
    if (pending.size() == 0) begin
      report("result with nothing expected");
      return;
    end
    want = pending.pop_front();
    if (got.num_out !== want.num_out)
      report($sformatf("num_out %0d want %0d", got.num_out, want.num_out));
    if (got.den_out !== want.den_out)
      report($sformatf("den_out %0d want %0d", got.den_out, want.den_out));
    if (got.status !== want.status)
      report($sformatf("status %0b want %0b", got.status, want.status));
  endtask
endclass

module tb_fraction_reduce_and_add_top;

  localparam int W = fra_pkg::OPERAND_WIDTH;
  localparam int IDLE_LIMIT = 20000;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  fra_pkg::in_word_t in_word;
  fra_pkg::out_word_t out_word;
  fraction_scoreboard sb;
  bit hold_long, stim_done;
  int idle_cycles;

  fraction_reduce_and_add_top uut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [W-1:0] pick_operand();
    unique case ($urandom_range(0, 9))
      0: return '0;
      1: return {1'b1, {(W-1){1'b0}}};
      2: return {1'b0, {(W-1){1'b1}}};
      3: return '1;
      4: return W'($urandom_range(1, 12));
      5: return W'(-int'($urandom_range(1, 12)));
      6: return W'($urandom_range(1, 4) * 60);
      default: return W'($urandom);
    endcase
  endfunction

  task automatic send_word(logic cmd, logic [W-1:0] na, logic [W-1:0] da,
                           logic [W-1:0] nb, logic [W-1:0] db);
    fra_pkg::in_word_t w;
    w.command = cmd;
    w.num_a = na;
    w.den_a = da;
    w.num_b = nb;
    w.den_b = db;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_random();
    logic cmd;
    cmd = $urandom_range(0, 1) ? fra_pkg::CMD_ADD : fra_pkg::CMD_REDUCE;
    send_word(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand());
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_word = '0;
    hold_long = 0;
    stim_done = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed corners
    send_word(fra_pkg::CMD_REDUCE, 16'sd6, 16'sd4, 16'sd9, 16'sd9);
    send_word(fra_pkg::CMD_REDUCE, -16'sd6, 16'sd4, 16'sd0, 16'sd0);
    send_word(fra_pkg::CMD_REDUCE, 16'sd6, -16'sd4, 16'sd1, 16'sd1);
    send_word(fra_pkg::CMD_REDUCE, -16'sd6, -16'sd4, 16'sd1, 16'sd1);
    send_word(fra_pkg::CMD_REDUCE, 16'sd0, -16'sd7, 16'sd1, 16'sd1);
    send_word(fra_pkg::CMD_REDUCE, 16'sd5, 16'sd0, 16'sd1, 16'sd1);
    send_word(fra_pkg::CMD_REDUCE, 16'h8000, 16'sd1, 16'sd0, 16'sd0);
    send_word(fra_pkg::CMD_REDUCE, 16'h8000, 16'h8000, 16'sd0, 16'sd0);
    send_word(fra_pkg::CMD_REDUCE, 16'sd1, 16'h8000, 16'sd0, 16'sd0);
    send_word(fra_pkg::CMD_REDUCE, 16'h7FFF, 16'hFFFF, 16'sd0, 16'sd0);
    send_word(fra_pkg::CMD_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_word(fra_pkg::CMD_ADD, 16'sd1, 16'sd4, 16'sd1, 16'sd4);
    send_word(fra_pkg::CMD_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2);
    send_word(fra_pkg::CMD_ADD, 16'sd1, 16'sd3, -16'sd1, 16'sd2);
    send_word(fra_pkg::CMD_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd2);
    send_word(fra_pkg::CMD_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd0);
    send_word(fra_pkg::CMD_ADD, 16'h8000, 16'sd1, 16'h8000, 16'sd1);
    send_word(fra_pkg::CMD_ADD, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(fra_pkg::CMD_ADD, 16'h7FFF, 16'h8001, 16'h7FFF, 16'h7FFE);
    send_word(fra_pkg::CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(fra_pkg::CMD_ADD, 16'sd0, 16'sd5, 16'sd0, -16'sd3);
    // long receiver hold-off while the sender keeps offering
    hold_long = 1;
    repeat (6) send_random();
    hold_long = 0;
    // let everything drain
    pause_sender(1);
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);
    for (int i = 0; i < 480; i++) begin
      send_random();
      if ($urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 200));
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // receiver stall pattern
  initial begin
    int n;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_long);
        @(posedge clk);
      end
      n = $urandom_range(0, 3);
      out_stall <= (n == 0);
      repeat ($urandom_range(1, (n == 0) ? 120 : 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS fraction_reduce_and_add_top");
    else $display("FAIL fraction_reduce_and_add_top");
    $finish;
  end

  initial begin
    wait (rst_n);
    wait (idle_cycles >= IDLE_LIMIT);
    $display("FAIL fraction_reduce_and_add_top");
    $finish;
  end
endmodule
